### src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, skipped while reset is high
`define HBD_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, skipped while reset is high
`define HBD_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define HBD_ASSERT_NXT_ALWAYS(name, clk, ante, cons, msg) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/hbd_pkg.sv
// types, codes and helpers of the huffman tree bit decoder
`timescale 1ns / 1ps
`default_nettype none
package hbd_pkg;

  localparam int NODES_DEF         = 512;
  localparam int MAX_CODE_BITS_DEF = 32;

  localparam int SYM_W     = 8;
  localparam int CODE_W    = 32;
  localparam int LEN_W     = 6;
  localparam int BITIDX_W  = 7;
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 8;

  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_LOAD    = 2'd1;
  localparam logic [1:0] OP_BIT     = 2'd2;
  localparam logic [1:0] OP_RESTART = 2'd3;

  localparam logic [1:0] KIND_SYMBOL = 2'd0;
  localparam logic [1:0] KIND_NOCODE = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIT,
    ST_WALK,
    ST_LINK,
    ST_GROW
  } state_t;

  typedef struct packed {
    logic             valid;
    logic [1:0]       kind;
    logic [SYM_W-1:0] sym;
  } item_t;

  // code bit at a given position, zero above the code field
  function automatic logic code_bit(input logic [CODE_W-1:0] code,
                                    input logic [BITIDX_W-1:0] idx);
    logic res;
    res = 1'b0;
    if (idx < BITIDX_W'(CODE_W)) begin
      res = code[idx[4:0]];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

### src/hbd_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module hbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### src/hbd_ctrl.sv
// sequencer for tree loading and bit walking over the node ram
`timescale 1ns / 1ps
`default_nettype none
module hbd_ctrl #(
  parameter int NODES         = hbd_pkg::NODES_DEF,
  parameter int MAX_CODE_BITS = hbd_pkg::MAX_CODE_BITS_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    in_valid,
  input  wire logic [1:0]                              op,
  input  wire logic [hbd_pkg::SYM_W-1:0]               symbol,
  input  wire logic [hbd_pkg::CODE_W-1:0]              code,
  input  wire logic [hbd_pkg::LEN_W-1:0]               code_len,
  input  wire logic                                    bit_req,
  input  wire logic                                    out_free,
  output logic                                         in_ready,
  output hbd_pkg::item_t                               emit,
  output logic                                         mem_we,
  output logic [$clog2(NODES)-1:0]                     mem_waddr,
  output logic [2*$clog2(NODES)+hbd_pkg::SYM_W-1:0]    mem_wdata,
  output logic [$clog2(NODES)-1:0]                     mem_raddr,
  input  wire logic [2*$clog2(NODES)+hbd_pkg::SYM_W-1:0] mem_rdata
);
  import hbd_pkg::*;

  localparam int IW   = $clog2(NODES);
  localparam int LW   = 2 * IW;
  localparam int RW   = LW + SYM_W;
  localparam int FCW  = $clog2(NODES + 1);
  localparam int JW   = $clog2(MAX_CODE_BITS + 1);
  localparam int CMPW = ((FCW > BITIDX_W) ? FCW : BITIDX_W) + 1;

  state_t state, state_next;

  logic [LW-1:0]    root_links, root_links_next;
  logic [LW-1:0]    cur_links, cur_links_next;
  logic [IW-1:0]    walk_node, walk_node_next;
  logic             failed, failed_next;
  logic [FCW-1:0]   free_count, free_count_next;

  logic [IW-1:0]    node, node_next;
  logic [JW-1:0]    step, step_next;
  logic [IW-1:0]    child_reg, child_reg_next;
  logic [RW-1:0]    par_word, par_word_next;
  logic [IW-1:0]    par_node, par_node_next;
  logic             par_bit, par_bit_next;
  logic [SYM_W-1:0] ld_sym;
  logic [CODE_W-1:0] ld_code;
  logic [LEN_W-1:0] ld_len;

  logic             accept;
  logic [LW-1:0]    walk_word;
  logic [IW-1:0]    bit_child;
  logic [RW-1:0]    load_word;
  logic             load_bit;
  logic [IW-1:0]    load_child;
  logic [CMPW-1:0]  missing;
  logic [CMPW-1:0]  avail;
  logic             last_step;
  logic             grow_bit;
  logic [IW-1:0]    grow_next_idx;
  logic [LW-1:0]    grow_links;
  logic [RW-1:0]    link_word;

  assign accept    = in_valid && in_ready;
  assign walk_word = (walk_node == '0) ? root_links : cur_links;
  assign bit_child = bit_req ? walk_word[LW-1:IW] : walk_word[IW-1:0];

  assign load_word  = (node == '0) ? {{SYM_W{1'b0}}, root_links} : mem_rdata;
  assign load_bit   = code_bit(ld_code, BITIDX_W'(ld_len) - BITIDX_W'(step));
  assign load_child = load_bit ? load_word[LW-1:IW] : load_word[IW-1:0];
  assign missing    = CMPW'(ld_len) - CMPW'(step) + CMPW'(1);
  assign avail      = CMPW'(NODES) - CMPW'(free_count);
  assign last_step  = (JW'(ld_len) == step);

  assign grow_bit      = code_bit(ld_code, BITIDX_W'(ld_len) - BITIDX_W'(step) - BITIDX_W'(1));
  assign grow_next_idx = IW'(free_count + FCW'(1));
  assign grow_links    = grow_bit ? {grow_next_idx, {IW{1'b0}}} : {{IW{1'b0}}, grow_next_idx};

  always_comb begin
    link_word = par_word;
    if (par_bit) begin
      link_word[LW-1:IW] = IW'(free_count);
    end else begin
      link_word[IW-1:0] = IW'(free_count);
    end
  end

  always_comb begin
    state_next      = state;
    root_links_next = root_links;
    cur_links_next  = cur_links;
    walk_node_next  = walk_node;
    failed_next     = failed;
    free_count_next = free_count;
    node_next       = node;
    step_next       = step;
    child_reg_next  = child_reg;
    par_word_next   = par_word;
    par_node_next   = par_node;
    par_bit_next    = par_bit;
    in_ready        = 1'b0;
    emit            = '0;
    mem_we          = 1'b0;
    mem_waddr       = IW'(free_count);
    mem_wdata       = '0;
    mem_raddr       = child_reg;

    unique case (state)
      ST_IDLE: begin
        in_ready  = out_free;
        mem_raddr = bit_child;
        if (accept) begin
          unique case (op)
            OP_CLEAR: begin
              root_links_next = '0;
              free_count_next = FCW'(1);
              walk_node_next  = '0;
              failed_next     = 1'b0;
            end
            OP_LOAD: begin
              if (code_len == '0 || CMPW'(code_len) > CMPW'(MAX_CODE_BITS)) begin
                emit = '{valid: 1'b1, kind: KIND_REJECT, sym: '0};
              end else begin
                node_next  = '0;
                step_next  = JW'(1);
                state_next = ST_WALK;
              end
            end
            OP_BIT: begin
              if (!failed) begin
                if (bit_child == '0) begin
                  emit           = '{valid: 1'b1, kind: KIND_NOCODE, sym: '0};
                  failed_next    = 1'b1;
                  walk_node_next = '0;
                end else begin
                  child_reg_next = bit_child;
                  state_next     = ST_BIT;
                end
              end
            end
            OP_RESTART: begin
              walk_node_next = '0;
              failed_next    = 1'b0;
            end
            default: ;
          endcase
        end
      end

      ST_BIT: begin
        mem_raddr = child_reg;
        if (mem_rdata[LW-1:0] == '0) begin
          // leaf: wait for the output slot, then report and go back to root
          if (out_free) begin
            emit           = '{valid: 1'b1, kind: KIND_SYMBOL, sym: mem_rdata[RW-1:LW]};
            walk_node_next = '0;
            state_next     = ST_IDLE;
          end
        end else begin
          walk_node_next = child_reg;
          cur_links_next = mem_rdata[LW-1:0];
          state_next     = ST_IDLE;
        end
      end

      ST_WALK: begin
        mem_raddr = node;
        if (load_child == '0) begin
          if (missing > avail) begin
            if (out_free) begin
              emit       = '{valid: 1'b1, kind: KIND_REJECT, sym: '0};
              state_next = ST_IDLE;
            end
          end else begin
            par_word_next = load_word;
            par_node_next = node;
            par_bit_next  = load_bit;
            state_next    = ST_LINK;
          end
        end else if (last_step) begin
          state_next = ST_IDLE;
        end else begin
          mem_raddr = load_child;
          node_next = load_child;
          step_next = step + JW'(1);
        end
      end

      ST_LINK: begin
        if (par_node == '0) begin
          root_links_next = link_word[LW-1:0];
        end else begin
          mem_we    = 1'b1;
          mem_waddr = par_node;
          mem_wdata = link_word;
          if (par_node == walk_node) begin
            cur_links_next = link_word[LW-1:0];
          end
        end
        state_next = ST_GROW;
      end

      ST_GROW: begin
        mem_we          = 1'b1;
        mem_waddr       = IW'(free_count);
        free_count_next = free_count + FCW'(1);
        if (last_step) begin
          mem_wdata  = {ld_sym, {LW{1'b0}}};
          state_next = ST_IDLE;
        end else begin
          mem_wdata = {{SYM_W{1'b0}}, grow_links};
          step_next = step + JW'(1);
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      root_links <= '0;
      walk_node  <= '0;
      failed     <= 1'b0;
      free_count <= FCW'(1);
    end else begin
      state      <= state_next;
      root_links <= root_links_next;
      walk_node  <= walk_node_next;
      failed     <= failed_next;
      free_count <= free_count_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_links <= cur_links_next;
    node      <= node_next;
    step      <= step_next;
    child_reg <= child_reg_next;
    par_word  <= par_word_next;
    par_node  <= par_node_next;
    par_bit   <= par_bit_next;
    if (accept) begin
      ld_sym  <= symbol;
      ld_code <= code;
      ld_len  <= code_len;
    end
  end

endmodule
`default_nettype wire

### src/huffman_tree_bit_decoder.sv
// huffman tree bit decoder: node ram, sequencer and output register
// code bit: the accept, then ST_BIT for one dependent node ram read when the child exists,
//   the accept alone when the child is missing or the walker has failed
// load entry: the accept, a walk step per existing path node plus the missing step,
//   one write for the parent link and one per new node; an existing path or a reject writes nothing
// clear table and restart stream: no result; a held result stalls the input
// reset: synchronous, root links cleared, one node in use, walker at root; no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module huffman_tree_bit_decoder #(
  parameter int NODES         = hbd_pkg::NODES_DEF,
  parameter int MAX_CODE_BITS = hbd_pkg::MAX_CODE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // input items
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // symbol [7:0], code [39:8], code_len [45:40], bit_req [46], zero pad [47]
  input  wire logic [hbd_pkg::S_TDATA_W-1:0]   s_tdata,
  // op [1:0]
  input  wire logic [1:0]                      s_tuser,
  // result items
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // symbol_res [7:0]
  output logic [hbd_pkg::M_TDATA_W-1:0]        m_tdata,
  // kind [1:0]
  output logic [1:0]                           m_tuser
);
  import hbd_pkg::*;

  localparam int IW = $clog2(NODES);
  // one ram word per node: {symbol, right child, left child}
  localparam int RW = 2 * IW + SYM_W;

  logic          out_free;
  item_t         emit;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [RW-1:0] mem_wdata;
  logic [IW-1:0] mem_raddr;
  logic [RW-1:0] mem_rdata;

  // output slot frees up in the same cycle the result is taken
  assign out_free = !m_tvalid || m_tready;

  // node store: child links and symbol of every node but the root,
  // the root links live in registers inside the sequencer
  hbd_ram #(
    .WIDTH (RW),
    .DEPTH (NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // load walk, path growth and bit walk
  hbd_ctrl #(
    .NODES         (NODES),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .op        (s_tuser),
    .symbol    (s_tdata[7:0]),
    .code      (s_tdata[39:8]),
    .code_len  (s_tdata[45:40]),
    .bit_req   (s_tdata[46]),
    .out_free  (out_free),
    .in_ready  (s_tready),
    .emit      (emit),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // output register, loaded only when the slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      m_tdata <= emit.sym;
      m_tuser <= emit.kind;
    end
  end

endmodule
`default_nettype wire

### src/hbd_checker.sv
// port checker for the huffman tree bit decoder and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module hbd_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_tvalid,
  input wire logic                          s_tready,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [hbd_pkg::M_TDATA_W-1:0] m_tdata,
  input wire logic [1:0]                    m_tuser
);
  import hbd_pkg::*;

  // no result kind beyond reject
  `HBD_ASSERT_IMP(a_kind_range, clk, rst, m_tvalid, m_tuser != 2'd3, "bad result kind")

  // only decoded symbols carry a nonzero byte
  `HBD_ASSERT_IMP(a_sym_zero, clk, rst, m_tvalid && (m_tuser != KIND_SYMBOL), m_tdata == '0, "symbol on non-symbol result")

  // an item is taken only when the output slot can hold its result
  `HBD_ASSERT_IMP(a_room_on_accept, clk, rst, s_tvalid && s_tready, !m_tvalid || m_tready, "accept with full output")

  // a stalled result holds
  `HBD_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

  // nothing pending right after reset
  `HBD_ASSERT_NXT_ALWAYS(a_reset_empty, clk, rst, !m_tvalid, "result valid after reset")

endmodule

bind huffman_tree_bit_decoder hbd_checker u_hbd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire

### test/huffman_tree_bit_decoder_test.sv
// testbench of the huffman tree bit decoder: code tree scoreboard, stream drivers and checks
`timescale 1ns / 1ps

typedef struct packed {
  logic [1:0] kind;
  logic [7:0] sym;
} decode_result_t;

// mirrors the node store and the walker, and holds the results still owed by the block
class code_tree_scoreboard;
  logic [8:0] child [hbd_pkg::NODES_DEF][2];
  logic [7:0] leaf_sym [hbd_pkg::NODES_DEF];
  int unsigned nodes_used;
  int unsigned walker;
  bit stuck;
  decode_result_t owed_q[$];
  int errors;
  int n_sym;
  int n_nocode;
  int n_reject;

  function new();
    child[0][0] = '0;
    child[0][1] = '0;
    nodes_used = 1;
    walker = 0;
    stuck = 1'b0;
    errors = 0;
    n_sym = 0;
    n_nocode = 0;
    n_reject = 0;
  endfunction

  // insert one table entry as a root-to-leaf path, or reject it whole
  function void add_code(logic [7:0] sym, logic [31:0] code, logic [5:0] len);
    int ln;
    int missing;
    int unsigned n;
    logic [8:0] c;
    logic d;
    ln = int'(len);
    if (ln == 0 || ln > hbd_pkg::MAX_CODE_BITS_DEF) begin
      owed_q.push_back(decode_result_t'{kind: hbd_pkg::KIND_REJECT, sym: 8'h00});
      return;
    end
    n = 0;
    missing = 0;
    for (int j = 1; j <= ln; j++) begin
      c = child[n][code[ln-j]];
      if (c == 0) begin
        missing = ln - j + 1;
        break;
      end
      n = 32'(c);
    end
    if (missing > hbd_pkg::NODES_DEF - nodes_used) begin
      owed_q.push_back(decode_result_t'{kind: hbd_pkg::KIND_REJECT, sym: 8'h00});
      return;
    end
    n = 0;
    for (int j = 1; j <= ln; j++) begin
      d = code[ln-j];
      c = child[n][d];
      if (c == 0) begin
        c = nodes_used[8:0];
        nodes_used++;
        child[c][0] = '0;
        child[c][1] = '0;
        leaf_sym[c] = (j == ln) ? sym : 8'h00;
        child[n][d] = c;
      end
      n = 32'(c);
    end
  endfunction

  function void step_walker(logic b);
    logic [8:0] c;
    c = child[walker][b];
    if (c == 0) begin
      stuck = 1'b1;
      walker = 0;
      owed_q.push_back(decode_result_t'{kind: hbd_pkg::KIND_NOCODE, sym: 8'h00});
    end else if (child[c][0] == 0 && child[c][1] == 0) begin
      walker = 0;
      owed_q.push_back(decode_result_t'{kind: hbd_pkg::KIND_SYMBOL, sym: leaf_sym[c]});
    end else begin
      walker = 32'(c);
    end
  endfunction

  // returns 0 for an item the block ignores (code bit while failed)
  function bit note_input(logic [1:0] op, logic [7:0] sym, logic [31:0] code,
                          logic [5:0] len, logic b);
    case (op)
      hbd_pkg::OP_CLEAR: begin
        child[0][0] = '0;
        child[0][1] = '0;
        nodes_used = 1;
        walker = 0;
        stuck = 1'b0;
      end
      hbd_pkg::OP_LOAD: add_code(sym, code, len);
      hbd_pkg::OP_BIT: begin
        if (stuck) return 1'b0;
        step_walker(b);
      end
      default: begin
        walker = 0;
        stuck = 1'b0;
      end
    endcase
    return 1'b1;
  endfunction

  // a bit that mostly follows an existing branch, so that streams reach the leaves
  function logic pick_bit();
    logic has0;
    logic has1;
    has0 = (child[walker][0] != 0);
    has1 = (child[walker][1] != 0);
    if (has0 && has1) return 1'($urandom_range(0, 1));
    if (has0) return ($urandom_range(0, 9) == 0);
    if (has1) return ($urandom_range(0, 9) != 0);
    return 1'($urandom_range(0, 1));
  endfunction

  function void check_result(logic [1:0] kind, logic [7:0] sym);
    decode_result_t want;
    if (owed_q.size() == 0) begin
      errors++;
      $display("%0t: result with nothing owed, kind %0d symbol 0x%02h", $time, kind, sym);
      return;
    end
    want = owed_q.pop_front();
    if (kind !== want.kind) begin
      errors++;
      $display("%0t: kind mismatch, expected %0d, got %0d", $time, want.kind, kind);
    end
    if (sym !== want.sym) begin
      errors++;
      $display("%0t: symbol mismatch, expected 0x%02h, got 0x%02h", $time, want.sym, sym);
    end
    case (want.kind)
      hbd_pkg::KIND_SYMBOL: n_sym++;
      hbd_pkg::KIND_NOCODE: n_nocode++;
      default: n_reject++;
    endcase
  endfunction
endclass

module huffman_tree_bit_decoder_test;
  import hbd_pkg::*;

  localparam int IDLE_LIMIT   = 4000;  // cycles without any item moving
  localparam int DRAIN_CYCLES = 64;    // margin over the longest load, a 32-bit code
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AT      = 300;   // items in before the long output hold-off
  localparam int RANDOM_ITEMS = 1350;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [1:0] s_tuser = OP_CLEAR;
  logic m_tready = 1'b0;
  logic s_tready;
  logic m_tvalid;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [1:0] m_tuser;

  code_tree_scoreboard sb = new();
  int unsigned items_in = 0;
  int unsigned in_stalls = 0;
  int unsigned out_holds = 0;
  bit quiet = 1'b0;
  bit hold_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  huffman_tree_bit_decoder DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // mostly short gaps, now and then a long one; none in quiet stretches
  function int gap_cycles();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // offer one item on the falling edge and hold it until the block takes it
  task send_item(logic [1:0] op, logic [7:0] sym, logic [31:0] code, logic [5:0] len,
                 logic b);
    int gap;
    gap = gap_cycles();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {1'b0, b, len, code, sym};
    do @(posedge clk); while (!s_tready);
    if (sb.note_input(op, sym, code, len, b)) items_in++;
  endtask

  task load_code(logic [7:0] sym, logic [31:0] code, logic [5:0] len);
    send_item(OP_LOAD, sym, code, len, 1'($urandom_range(0, 1)));
  endtask

  // unused fields carry random junk that the block must ignore
  task send_bit(logic b);
    send_item(OP_BIT, 8'($urandom), $urandom, 6'($urandom_range(0, 63)), b);
  endtask

  task send_ctrl(logic [1:0] op);
    send_item(op, 8'($urandom), $urandom, 6'($urandom_range(0, 63)),
              1'($urandom_range(0, 1)));
  endtask

  // short codes mostly, some long ones, some empty or overlong
  task load_random();
    int r;
    logic [5:0] len;
    r = $urandom_range(0, 99);
    if (r < 78) len = 6'($urandom_range(1, 8));
    else if (r < 90) len = 6'($urandom_range(9, 32));
    else if (r < 95) len = 6'd0;
    else len = 6'($urandom_range(33, 63));
    load_code(8'($urandom), $urandom, len);
  endtask

  // code bits that follow the tree, with stray bits, restarts, reloads and clears mixed in
  task decode_stream(int steps);
    int r;
    for (int i = 0; i < steps; i++) begin
      r = $urandom_range(0, 99);
      if (sb.stuck && r < 80) send_ctrl(OP_RESTART);
      else if (r < 85) send_bit(sb.pick_bit());
      else if (r < 90) send_bit(1'($urandom_range(0, 1)));
      else if (r < 95) send_ctrl(OP_RESTART);
      else if (r < 99) load_random();
      else send_ctrl(OP_CLEAR);
    end
  endtask

  // long codes until the node store runs out, then decode through the deep tree
  task fill_store();
    send_ctrl(OP_CLEAR);
    repeat (20) load_code(8'($urandom), $urandom, 6'($urandom_range(26, 32)));
    repeat (4) load_random();
    decode_stream(60);
  endtask

  // receiver: random stalls, one long hold-off so the block backs up into its input
  initial begin
    int stall_left;
    stall_left = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!hold_done && items_in >= HOLD_AT) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 7) == 0) stall_left = gap_cycles();
      end
    end
  end

  // result checks and the progress watchdog
  initial begin
    int idle;
    idle = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
      if (s_tvalid && !s_tready) in_stalls++;
      if (m_tvalid && !m_tready) out_holds++;
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
      else idle++;
    end
    $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int unsigned goal;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty table, then a bit while failed
    send_bit(1'b1);
    send_bit(1'b0);
    send_ctrl(OP_RESTART);
    // empty and overlong entries
    load_code(8'h11, 32'h0000_0001, 6'd0);
    load_code(8'h22, 32'hFFFF_FFFF, 6'd33);
    load_code(8'h33, 32'h8000_0000, 6'd63);
    // longest code, shortest code, prefix of an existing path
    load_code(8'hFF, 32'hFFFF_FFFF, 6'd32);
    load_code(8'h00, 32'h0000_0000, 6'd1);
    load_code(8'hA5, 32'h0000_FFFF, 6'd16);
    // entry through the leaf "0", and a duplicate of the long code
    load_code(8'h5A, 32'hFFFF_FFF1, 6'd2);
    load_code(8'h3C, 32'hFFFF_FFFF, 6'd32);
    send_bit(1'b0);
    send_bit(1'b1);
    // "00" now has no child
    send_bit(1'b0);
    send_bit(1'b0);
    send_bit(1'b1);
    send_ctrl(OP_RESTART);
    // new branch "10" beside the long code
    load_code(8'h81, 32'hFFFF_FFFE, 6'd2);
    send_bit(1'b1);
    send_bit(1'b0);
    send_ctrl(OP_CLEAR);
    send_bit(1'b0);
    send_ctrl(OP_RESTART);

    goal = items_in + RANDOM_ITEMS;
    fill_store();
    while (items_in < goal) begin
      quiet = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 11) == 0) begin
        fill_store();
      end else begin
        if ($urandom_range(0, 9) < 7) send_ctrl(OP_CLEAR);
        repeat ($urandom_range(2, 16)) load_random();
        decode_stream($urandom_range(20, 80));
      end
    end
    quiet = 1'b0;
    @(negedge clk);
    s_tvalid <= 1'b0;

    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d items taken: %0d symbols decoded, %0d missing codes, %0d loads rejected",
             items_in, sb.n_sym, sb.n_nocode, sb.n_reject);
    $display("input stalled %0d cycles, results held back %0d cycles", in_stalls, out_holds);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/hbd_pkg.sv
src/hbd_ram.sv
src/hbd_ctrl.sv
src/huffman_tree_bit_decoder.sv
src/hbd_checker.sv
test/huffman_tree_bit_decoder_test.sv
